### src/sdes_pkg.sv
`default_nettype none
package sdes_pkg;

  localparam int EXP_W    = 21;
  localparam int SHARE_W  = 17;
  localparam int THR_W    = 12;
  localparam int FACT_W   = 17;
  localparam int Q_FRAC   = 16;
  localparam int PROD_W   = EXP_W + FACT_W;
  localparam int SCALED_W = PROD_W + 1 - Q_FRAC;

  localparam int APB_ADDR_W = 4;
  localparam int APB_DATA_W = 32;

  localparam logic [EXP_W-1:0] EXP_MAX = '1;

  localparam logic [SHARE_W-1:0] Q_ONE   = 17'd65536;
  localparam logic [SHARE_W-1:0] Q_HALF  = 17'd32768;
  localparam logic [SHARE_W-1:0] Q_TENTH = 17'd6554;
  localparam logic [SHARE_W-1:0] Q_MILLI = 17'd66;
  localparam logic [FACT_W-1:0]  Q_0_90  = 17'd58982;
  localparam logic [FACT_W-1:0]  Q_1_35  = 17'd88474;
  localparam logic [FACT_W-1:0]  Q_1_05  = 17'd68813;
  localparam logic [PROD_W:0]    ROUND_BIAS = (PROD_W+1)'(32768);

  localparam logic [THR_W-1:0]   THR_RESET     = 12'd4094;
  localparam logic [SHARE_W-1:0] TARGET_RESET  = 17'd65536;
  localparam logic [EXP_W-1:0]   MAX_EXP_RESET = 21'd2048000;

  // Register indexes on the configuration port (word address).
  localparam logic [1:0] REG_THRESHOLD = 2'd0;
  localparam logic [1:0] REG_TARGET    = 2'd1;
  localparam logic [1:0] REG_MAX_EXP   = 2'd2;

  typedef struct packed {
    logic [EXP_W-1:0]   new_exposure;
    logic               set_exposure;
    logic               search_done;
    logic [EXP_W-1:0]   chosen_exposure;
    logic [SHARE_W-1:0] saturated_share;
  } result_t;

  // Cut factor: 0.9 for a small share, otherwise one minus the share.
  function automatic logic [FACT_W-1:0] cut_factor(input logic [SHARE_W-1:0] s);
    logic [FACT_W-1:0] f;
    f = (s < Q_TENTH) ? Q_0_90 : (Q_ONE - s);
    return f;
  endfunction

  function automatic logic [EXP_W-1:0] sat_exp(input logic [SCALED_W-1:0] v);
    logic [EXP_W-1:0] e;
    e = (v > SCALED_W'(EXP_MAX)) ? EXP_MAX : v[EXP_W-1:0];
    return e;
  endfunction

endpackage
`default_nettype wire

### src/saturation_driven_exposure_search.sv
// A pixel without the frame-end mark gives no result.
// A frame-end pixel starts a 17-step restoring divider for the saturated share, then a
// decision as the share arrives and a multiply state; the emit state then passes its result on.
// One pixel per cycle within a frame; the input is held off while a frame end is in progress.
// Reset: configuration returns to its defaults, the frame counters clear and the search
// goes back to phase one with no reduction made and a chosen exposure of zero.
`default_nettype none
module saturation_driven_exposure_search import sdes_pkg::*; #(
  parameter int PIXEL_BITS       = 12,
  parameter int FRAME_COUNT_BITS = 24
) (
  input  wire logic                  clk_i,
  input  wire logic                  rst_ni,
  input  wire logic                  in_valid_i,
  output logic                       in_ready_o,
  input  wire logic [PIXEL_BITS-1:0] pixel_value_i,
  input  wire logic                  last_of_frame_i,
  input  wire logic [EXP_W-1:0]      reported_exposure_i,
  input  wire logic                  begin_search_i,
  output logic                       out_valid_o,
  input  wire logic                  out_ready_i,
  output logic      [EXP_W-1:0]      new_exposure_o,
  output logic                       set_exposure_o,
  output logic                       search_done_o,
  output logic      [EXP_W-1:0]      chosen_exposure_o,
  output logic      [SHARE_W-1:0]    saturated_share_o,
  input  wire logic                  psel,
  input  wire logic                  penable,
  input  wire logic                  pwrite,
  input  wire logic [APB_ADDR_W-1:0] paddr,
  input  wire logic [APB_DATA_W-1:0] pwdata,
  output logic      [APB_DATA_W-1:0] prdata,
  output logic                       pready
);

  logic [THR_W-1:0]            thr_q;
  logic [SHARE_W-1:0]          target_q;
  logic [EXP_W-1:0]            max_exp_q;
  logic                        cfg_write;
  logic [1:0]                  reg_idx;

  logic                        accept;
  logic [FRAME_COUNT_BITS-1:0] sat_count, pix_count;
  logic                        div_busy, div_done;
  logic [SHARE_W-1:0]          share;
  logic                        search_idle, res_valid, res_ready;
  result_t                     res, out_q;
  logic                        out_valid_q;

  assign pready    = 1'b1;
  assign cfg_write = psel && penable && pwrite;
  assign reg_idx   = paddr[APB_ADDR_W-1:2];

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      thr_q     <= THR_RESET;
      target_q  <= TARGET_RESET;
      max_exp_q <= MAX_EXP_RESET;
    end else if (cfg_write) begin
      unique case (reg_idx)
        REG_THRESHOLD: thr_q     <= pwdata[THR_W-1:0];
        REG_TARGET:    target_q  <= pwdata[SHARE_W-1:0];
        REG_MAX_EXP:   max_exp_q <= pwdata[EXP_W-1:0];
        default: ;
      endcase
    end
  end

  always_comb begin
    unique case (reg_idx)
      REG_THRESHOLD: prdata = APB_DATA_W'(thr_q);
      REG_TARGET:    prdata = APB_DATA_W'(target_q);
      REG_MAX_EXP:   prdata = APB_DATA_W'(max_exp_q);
      default:       prdata = '0;
    endcase
  end

  assign in_ready_o = search_idle && !div_busy && !div_done;
  assign accept     = in_valid_i && in_ready_o;

  sdes_frame_acc #(
    .PIXEL_BITS      (PIXEL_BITS),
    .FRAME_COUNT_BITS(FRAME_COUNT_BITS)
  ) u_acc (
    .clk_i      (clk_i),
    .rst_ni     (rst_ni),
    .accept_i   (accept),
    .pixel_i    (pixel_value_i),
    .last_i     (last_of_frame_i),
    .threshold_i(thr_q),
    .sat_count_o(sat_count),
    .pix_count_o(pix_count)
  );

  sdes_div #(
    .W(FRAME_COUNT_BITS)
  ) u_div (
    .clk_i     (clk_i),
    .rst_ni    (rst_ni),
    .start_i   (accept && last_of_frame_i),
    .dividend_i(sat_count),
    .divisor_i (pix_count),
    .busy_o    (div_busy),
    .done_o    (div_done),
    .quotient_o(share)
  );

  sdes_search u_search (
    .clk_i        (clk_i),
    .rst_ni       (rst_ni),
    .accept_i     (accept),
    .begin_i      (begin_search_i),
    .last_i       (last_of_frame_i),
    .rep_i        (reported_exposure_i),
    .target_i     (target_q),
    .max_i        (max_exp_q),
    .share_valid_i(div_done),
    .share_i      (share),
    .res_ready_i  (res_ready),
    .idle_o       (search_idle),
    .res_valid_o  (res_valid),
    .res_o        (res)
  );

  // The output register lets new pixels in while a result waits downstream.
  assign res_ready = !out_valid_q || out_ready_i;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      out_valid_q <= 1'b0;
    end else if (res_valid && res_ready) begin
      out_valid_q <= 1'b1;
    end else if (out_ready_i) begin
      out_valid_q <= 1'b0;
    end
  end

  always_ff @(posedge clk_i) begin
    if (res_valid && res_ready) begin
      out_q <= res;
    end
  end

  assign out_valid_o       = out_valid_q;
  assign new_exposure_o    = out_q.new_exposure;
  assign set_exposure_o    = out_q.set_exposure;
  assign search_done_o     = out_q.search_done;
  assign chosen_exposure_o = out_q.chosen_exposure;
  assign saturated_share_o = out_q.saturated_share;

endmodule
`default_nettype wire

### src/sdes_frame_acc.sv
`default_nettype none
module sdes_frame_acc import sdes_pkg::*; #(
  parameter int PIXEL_BITS       = 12,
  parameter int FRAME_COUNT_BITS = 24
) (
  input  wire logic                        clk_i,
  input  wire logic                        rst_ni,
  input  wire logic                        accept_i,
  input  wire logic [PIXEL_BITS-1:0]       pixel_i,
  input  wire logic                        last_i,
  input  wire logic [THR_W-1:0]            threshold_i,
  output logic      [FRAME_COUNT_BITS-1:0] sat_count_o,
  output logic      [FRAME_COUNT_BITS-1:0] pix_count_o
);

  localparam int CMP_W = (PIXEL_BITS > THR_W) ? PIXEL_BITS : THR_W;
  localparam logic [FRAME_COUNT_BITS-1:0] CMAX = '1;

  logic [FRAME_COUNT_BITS-1:0] sat_q, pix_q;
  logic                        is_sat;

  assign is_sat      = CMP_W'(pixel_i) > CMP_W'(threshold_i);
  // Both counters stick at their maximum instead of wrapping.
  assign pix_count_o = (pix_q == CMAX) ? pix_q : pix_q + 1'b1;
  assign sat_count_o = (is_sat && sat_q != CMAX) ? sat_q + 1'b1 : sat_q;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      sat_q <= '0;
      pix_q <= '0;
    end else if (accept_i) begin
      if (last_i) begin
        sat_q <= '0;
        pix_q <= '0;
      end else begin
        sat_q <= sat_count_o;
        pix_q <= pix_count_o;
      end
    end
  end

endmodule
`default_nettype wire

### src/sdes_div.sv
`default_nettype none
module sdes_div import sdes_pkg::*; #(
  parameter int W = 24
) (
  input  wire logic               clk_i,
  input  wire logic               rst_ni,
  input  wire logic               start_i,
  input  wire logic [W-1:0]       dividend_i,
  input  wire logic [W-1:0]       divisor_i,
  output logic                    busy_o,
  output logic                    done_o,
  output logic      [SHARE_W-1:0] quotient_o
);

  // Restoring division of dividend * 2^16 by divisor, one quotient bit a cycle.
  // The dividend never exceeds the divisor, so the quotient fits in 17 bits.
  localparam int STEPS = SHARE_W;
  localparam int CNT_W = $clog2(STEPS);
  localparam logic [CNT_W-1:0] LAST_STEP = CNT_W'(STEPS - 1);

  logic [W:0]         r_q;
  logic [W-1:0]       d_q;
  logic [SHARE_W-1:0] q_q;
  logic [CNT_W-1:0]   cnt_q;
  logic               busy_q, done_q;
  logic [W+1:0]       diff;
  logic               ge;
  logic [W:0]         rem;

  assign diff = {1'b0, r_q} - {2'b00, d_q};
  assign ge   = !diff[W+1];
  assign rem  = ge ? diff[W:0] : r_q;

  always_ff @(posedge clk_i) begin
    if (start_i) begin
      r_q <= {1'b0, dividend_i};
      d_q <= divisor_i;
      q_q <= '0;
    end else if (busy_q) begin
      r_q <= {rem[W-1:0], 1'b0};
      q_q <= {q_q[SHARE_W-2:0], ge};
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      busy_q <= 1'b0;
      done_q <= 1'b0;
      cnt_q  <= '0;
    end else begin
      done_q <= 1'b0;
      if (start_i) begin
        busy_q <= 1'b1;
        cnt_q  <= '0;
      end else if (busy_q) begin
        cnt_q <= cnt_q + 1'b1;
        if (cnt_q == LAST_STEP) begin
          busy_q <= 1'b0;
          done_q <= 1'b1;
        end
      end
    end
  end

  assign busy_o     = busy_q;
  assign done_o     = done_q;
  assign quotient_o = q_q;

  a_done_latency: assert property (@(posedge clk_i) disable iff (!rst_ni)
    start_i |-> ##18 done_o)
    else $error("divider did not finish after its fixed number of steps");

  a_share_range: assert property (@(posedge clk_i) disable iff (!rst_ni)
    done_o |-> quotient_o <= Q_ONE)
    else $error("saturated share exceeds one");

endmodule
`default_nettype wire

### src/sdes_search.sv
`default_nettype none
module sdes_search import sdes_pkg::*; (
  input  wire logic               clk_i,
  input  wire logic               rst_ni,
  input  wire logic               accept_i,
  input  wire logic               begin_i,
  input  wire logic               last_i,
  input  wire logic [EXP_W-1:0]   rep_i,
  input  wire logic [SHARE_W-1:0] target_i,
  input  wire logic [EXP_W-1:0]   max_i,
  input  wire logic               share_valid_i,
  input  wire logic [SHARE_W-1:0] share_i,
  input  wire logic               res_ready_i,
  output logic                    idle_o,
  output logic                    res_valid_o,
  output result_t                 res_o
);

  typedef enum logic [1:0] {S_IDLE, S_MUL, S_EMIT} state_e;
  typedef enum logic [1:0] {PH_REDUCE, PH_RAISE, PH_REDUCE2, PH_FINISHED} phase_e;
  typedef enum logic [1:0] {ACT_NONE, ACT_CUT, ACT_RAISE, ACT_DONE} action_e;

  state_e             state_q;
  phase_e             phase_q, phase_d;
  action_e            act_q, act_d;
  logic               reduced_q;
  logic [EXP_W-1:0]   lce_q;
  logic [EXP_W-1:0]   rep_q;
  logic [SHARE_W-1:0] share_q;
  logic [FACT_W-1:0]  factor_q, factor_d;
  logic [PROD_W-1:0]  prod_q;

  logic [SHARE_W-1:0]  clamp;
  logic                below, p0_cut, go1, do_raise, go2;
  logic [PROD_W:0]     rounded;
  logic [SCALED_W-1:0] scaled;
  logic [EXP_W-1:0]    newe_sat, capped_lce;
  logic                over;

  // Decision for one frame end, taken in the cycle the share arrives.
  always_comb begin
    clamp    = (share_i > Q_HALF) ? Q_HALF : share_i;
    below    = share_i < target_i;
    p0_cut   = (phase_q == PH_REDUCE) && (clamp >= target_i);
    go1      = ((phase_q == PH_REDUCE) && !p0_cut) || (phase_q == PH_RAISE);
    do_raise = go1 && !reduced_q && below;
    go2      = (go1 && !do_raise) || (phase_q == PH_REDUCE2);
    act_d    = ACT_NONE;
    phase_d  = phase_q;
    factor_d = cut_factor(share_i);
    priority if (p0_cut) begin
      act_d    = ACT_CUT;
      factor_d = cut_factor(clamp);
    end else if (do_raise) begin
      act_d    = ACT_RAISE;
      phase_d  = PH_RAISE;
      factor_d = (share_i < Q_MILLI) ? Q_1_35 : Q_1_05;
    end else if (go2 && below) begin
      act_d   = ACT_DONE;
      phase_d = PH_FINISHED;
    end else if (go2) begin
      act_d   = ACT_CUT;
      phase_d = PH_REDUCE2;
    end else begin
      act_d = ACT_NONE;
    end
  end

  always_comb begin
    rounded    = {1'b0, prod_q} + ROUND_BIAS;
    scaled     = rounded[PROD_W:Q_FRAC];
    newe_sat   = sat_exp(scaled);
    over       = scaled > SCALED_W'(max_i);
    capped_lce = (lce_q > max_i) ? max_i : lce_q;
    res_o                 = '0;
    res_o.saturated_share = share_q;
    unique case (act_q)
      ACT_CUT: begin
        res_o.new_exposure = newe_sat;
        res_o.set_exposure = 1'b1;
      end
      ACT_RAISE: begin
        res_o.new_exposure = newe_sat;
        res_o.set_exposure = 1'b1;
        if (over) begin
          res_o.search_done     = 1'b1;
          res_o.chosen_exposure = max_i;
        end
      end
      ACT_DONE: begin
        res_o.search_done     = 1'b1;
        res_o.chosen_exposure = capped_lce;
      end
      default: ;
    endcase
  end

  always_ff @(posedge clk_i) begin
    if (accept_i && last_i) begin
      rep_q <= rep_i;
    end
    if (state_q == S_IDLE && share_valid_i) begin
      share_q  <= share_i;
      factor_q <= factor_d;
    end
    if (state_q == S_MUL) begin
      prod_q <= PROD_W'(rep_q) * PROD_W'(factor_q);
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q   <= S_IDLE;
      phase_q   <= PH_REDUCE;
      act_q     <= ACT_NONE;
      reduced_q <= 1'b0;
      lce_q     <= '0;
    end else begin
      unique case (state_q)
        S_IDLE: begin
          if (accept_i && begin_i) begin
            phase_q   <= PH_REDUCE;
            reduced_q <= 1'b0;
          end else if (share_valid_i) begin
            act_q   <= act_d;
            phase_q <= phase_d;
            if (p0_cut) begin
              reduced_q <= 1'b1;
            end
            state_q <= S_MUL;
          end
        end
        S_MUL: begin
          state_q <= S_EMIT;
        end
        S_EMIT: begin
          if (res_ready_i) begin
            unique case (act_q)
              ACT_CUT: lce_q <= newe_sat;
              ACT_RAISE: begin
                if (over) begin
                  lce_q   <= max_i;
                  phase_q <= PH_FINISHED;
                end else begin
                  lce_q <= scaled[EXP_W-1:0];
                end
              end
              default: ;
            endcase
            state_q <= S_IDLE;
          end
        end
        default: state_q <= S_IDLE;
      endcase
    end
  end

  assign idle_o      = (state_q == S_IDLE);
  assign res_valid_o = (state_q == S_EMIT);

  a_chosen_capped: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (res_valid_o && res_o.search_done) |-> res_o.chosen_exposure <= max_i)
    else $error("chosen exposure above the configured limit");

  a_unset_is_zero: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (res_valid_o && !res_o.set_exposure) |-> res_o.new_exposure == '0)
    else $error("exposure value present without a set request");

endmodule
`default_nettype wire
